>>> rtl/decimal_accumulator_machine_defines.svh
// ----------------------------------------------------------------------------
// Decimal accumulator machine - assertion macros
// Shared concurrent check helpers; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ACCUMULATOR_MACHINE_DEFINES_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_DEFINES_SVH

// same-cycle implication
`define DAM_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DAM_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dam_pkg.sv
// ----------------------------------------------------------------------------
// dam_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dam_pkg;

  localparam int MEM_WORDS = 100;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int WW        = 15;             // stored word, accumulator
  localparam int DW        = 16;             // input data value
  localparam int MAG_W     = WW - 1;         // magnitude of a word
  localparam int PROD_W    = 2 * MAG_W;
  localparam int STEP_W    = $clog2(MAG_W);
  localparam int WORD_MAX  = 9999;
  localparam int OP_RADIX  = 100;

  localparam logic signed [DW-1:0] LIM_HI = DW'(WORD_MAX);
  localparam logic signed [DW-1:0] LIM_LO = DW'(-WORD_MAX);

  // word / 100 by reciprocal multiply, exact for any 14-bit word
  localparam int          RECIP_W  = 13;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(5243);
  localparam int          RECIP_SH = 19;
  localparam int          DQ_W     = MAG_W + RECIP_W;
  localparam int          OP_W     = DQ_W - RECIP_SH;

  // stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 5;

  // request kinds
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_EXEC    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // result status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HALT     = 3'd1;
  localparam logic [2:0] ST_STOPPED  = 3'd2;
  localparam logic [2:0] ST_ACC_RNG  = 3'd3;
  localparam logic [2:0] ST_DIV_ZERO = 3'd4;
  localparam logic [2:0] ST_BAD_READ = 3'd5;
  localparam logic [2:0] ST_LOAD_REJ = 3'd6;
  localparam logic [2:0] ST_OFF_END  = 3'd7;

  // opcodes
  localparam logic [OP_W-1:0] OP_READ   = OP_W'(10);
  localparam logic [OP_W-1:0] OP_WRITE  = OP_W'(11);
  localparam logic [OP_W-1:0] OP_LOAD   = OP_W'(20);
  localparam logic [OP_W-1:0] OP_STORE  = OP_W'(21);
  localparam logic [OP_W-1:0] OP_ADD    = OP_W'(30);
  localparam logic [OP_W-1:0] OP_SUB    = OP_W'(31);
  localparam logic [OP_W-1:0] OP_DIV    = OP_W'(32);
  localparam logic [OP_W-1:0] OP_MUL    = OP_W'(33);
  localparam logic [OP_W-1:0] OP_BR     = OP_W'(40);
  localparam logic [OP_W-1:0] OP_BRNEG  = OP_W'(41);
  localparam logic [OP_W-1:0] OP_BRZERO = OP_W'(42);
  localparam logic [OP_W-1:0] OP_HALT   = OP_W'(43);

  typedef struct packed {
    logic cap;       // take the input item
    logic disp;      // dispatch on request kind, fetch word at pc
    logic dec;       // split fetched word into opcode and address
    logic oprd;      // read operand word
    logic exec;      // execute instruction
    logic mdfin;     // commit multiply / divide result
    logic load_out;  // move result into output register
  } dam_cmd_t;

  typedef struct packed {
    logic fetch_go;  // execute request with a word to fetch
    logic md_go;     // instruction needs the multiply / divide unit
    logic md_done;   // multiply / divide result ready
  } dam_sts_t;

endpackage

`default_nettype wire

>>> rtl/dam_muldiv.sv
// ----------------------------------------------------------------------------
// dam_muldiv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dam_muldiv import dam_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    is_div,
  input  logic signed [WW-1:0]    opa,
  input  logic signed [WW-1:0]    opb,
  output logic                    done,
  output logic                    res_neg,
  output logic [PROD_W-1:0]       res_mag
);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   cnt_r;
  logic                div_r;
  logic                neg_r;
  logic [MAG_W-1:0]    x_r;     // multiplier, or dividend shifting into quotient
  logic [MAG_W-1:0]    dvs_r;
  logic [PROD_W-1:0]   mc_r;
  logic [PROD_W-1:0]   p_r;     // product, or partial remainder
  logic [WW-1:0]       a_neg;
  logic [WW-1:0]       b_neg;
  logic [MAG_W-1:0]    a_mag;
  logic [MAG_W-1:0]    b_mag;
  logic [MAG_W:0]      rem_sh;
  logic [MAG_W:0]      rem_sub;
  logic                rem_ge;

  assign a_neg = -opa;
  assign b_neg = -opb;
  assign a_mag = opa[WW-1] ? a_neg[MAG_W-1:0] : opa[MAG_W-1:0];
  assign b_mag = opb[WW-1] ? b_neg[MAG_W-1:0] : opb[MAG_W-1:0];

  assign rem_sh  = {p_r[MAG_W-1:0], x_r[MAG_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      neg_r <= opa[WW-1] ^ opb[WW-1];
      x_r   <= a_mag;
      dvs_r <= b_mag;
      mc_r  <= PROD_W'(b_mag);
      p_r   <= '0;
    end else if (busy_r) begin
      if (div_r) begin
        if (rem_ge) begin
          p_r <= PROD_W'(rem_sub);
          x_r <= {x_r[MAG_W-2:0], 1'b1};
        end else begin
          p_r <= PROD_W'(rem_sh);
          x_r <= {x_r[MAG_W-2:0], 1'b0};
        end
      end else begin
        if (x_r[0]) begin
          p_r <= p_r + mc_r;
        end
        mc_r <= {mc_r[PROD_W-2:0], 1'b0};
        x_r  <= {1'b0, x_r[MAG_W-1:1]};
      end
    end
  end

  assign done    = done_r;
  assign res_neg = neg_r;
  assign res_mag = div_r ? PROD_W'(x_r) : p_r;

endmodule

`default_nettype wire

>>> rtl/dam_datapath.sv
// ----------------------------------------------------------------------------
// dam_datapath
// Word store, machine registers, decode, ALU and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dam_datapath import dam_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dam_cmd_t                cmd,
  output dam_sts_t                sts,
  input  logic [1:0]              item_req,
  input  logic [AW-1:0]           item_addr,
  input  logic signed [DW-1:0]    item_data,
  output logic [OUT_TDATA_W-1:0]  out_data,
  output logic [OUT_TUSER_W-1:0]  out_user
);

  // captured item
  logic [1:0]              req_r;
  logic [AW-1:0]           ldaddr_r;
  logic signed [DW-1:0]    data_r;

  // machine state
  logic signed [WW-1:0]    acc_r, acc_nxt;
  logic [AW-1:0]           pc_r, pc_nxt;
  logic                    stop_r, stop_nxt;

  // decoded instruction
  logic signed [WW-1:0]    word_r;
  logic [OP_W-1:0]         op_r;
  logic [AW-1:0]           ad_r;

  // result being built
  logic [2:0]              st_r, st_nxt;
  logic                    wv_r, wv_nxt;
  logic signed [WW-1:0]    wval_r, wval_nxt;
  logic                    ru_r, ru_nxt;
  logic signed [WW-1:0]    xw_r, xw_nxt;

  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic [OUT_TUSER_W-1:0]  out_user_r;

  // word store; entries never written read as zero
  logic [WW-1:0]           mem [MEM_WORDS];
  logic [MEM_WORDS-1:0]    vld_r;
  logic [WW-1:0]           rdata_r;
  logic                    rvld_r;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [WW-1:0]           wdata;
  logic                    mem_re;
  logic [AW-1:0]           raddr;

  logic signed [WW-1:0]    rword;
  logic                    data_ok;
  logic                    pc_over;
  logic [AW-1:0]           pc_inc;
  logic [DQ_W-1:0]         dq_prod;
  logic [OP_W-1:0]         dq;
  logic [MAG_W-1:0]        da_full;
  logic signed [DW-1:0]    t_add;
  logic signed [DW-1:0]    t_sub;
  logic signed [DW-1:0]    t_as;
  logic                    commit_pc;
  logic [AW-1:0]           npc;
  logic                    md_go;
  logic                    md_done;
  logic                    md_neg;
  logic [PROD_W-1:0]       md_mag;
  logic [WW-1:0]           md_pos;
  logic [WW-1:0]           md_negv;

  assign rword   = rvld_r ? $signed(rdata_r) : '0;
  assign data_ok = (data_r >= LIM_LO) && (data_r <= LIM_HI);
  assign pc_over = pc_r >= AW'(MEM_WORDS);
  assign pc_inc  = pc_r + 1'b1;

  // opcode = word / 100, address = word % 100
  assign dq_prod = DQ_W'(rword[MAG_W-1:0]) * DQ_W'(RECIP);
  assign dq      = dq_prod[DQ_W-1:RECIP_SH];
  assign da_full = rword[MAG_W-1:0] - MAG_W'(MAG_W'(dq) * MAG_W'(OP_RADIX));

  assign t_add = DW'(acc_r) + DW'(rword);
  assign t_sub = DW'(acc_r) - DW'(rword);
  assign t_as  = (op_r == OP_SUB) ? t_sub : t_add;

  assign md_go = !word_r[WW-1] &&
                 ((op_r == OP_MUL) || ((op_r == OP_DIV) && (rword != '0)));

  assign md_pos  = WW'(md_mag[MAG_W-1:0]);
  assign md_negv = -md_pos;

  assign sts.fetch_go = (req_r == REQ_EXEC) && !stop_r && !pc_over;
  assign sts.md_go    = md_go;
  assign sts.md_done  = md_done;

  dam_muldiv u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.exec && md_go),
    .is_div  (op_r == OP_DIV),
    .opa     (acc_r),
    .opb     (rword),
    .done    (md_done),
    .res_neg (md_neg),
    .res_mag (md_mag)
  );

  always_comb begin
    acc_nxt   = acc_r;
    pc_nxt    = pc_r;
    stop_nxt  = stop_r;
    st_nxt    = st_r;
    wv_nxt    = wv_r;
    wval_nxt  = wval_r;
    ru_nxt    = ru_r;
    xw_nxt    = xw_r;
    we        = 1'b0;
    waddr     = ldaddr_r;
    wdata     = data_r[WW-1:0];
    mem_re    = 1'b0;
    raddr     = pc_r;
    commit_pc = 1'b0;
    npc       = pc_inc;

    if (cmd.disp) begin
      st_nxt   = ST_OK;
      wv_nxt   = 1'b0;
      wval_nxt = '0;
      ru_nxt   = 1'b0;
      xw_nxt   = '0;
      unique case (req_r)
        REQ_LOAD: begin
          if ((ldaddr_r < AW'(MEM_WORDS)) && data_ok) begin
            we = 1'b1;
          end else begin
            st_nxt = ST_LOAD_REJ;
          end
        end
        REQ_EXEC: begin
          if (stop_r) begin
            st_nxt = ST_STOPPED;
          end else if (pc_over) begin
            st_nxt   = ST_OFF_END;
            stop_nxt = 1'b1;
          end else begin
            mem_re = 1'b1;
          end
        end
        REQ_RESTART: begin
          pc_nxt   = '0;
          acc_nxt  = '0;
          stop_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.dec) begin
      xw_nxt = rword;
    end

    if (cmd.oprd) begin
      mem_re = 1'b1;
      raddr  = ad_r;
    end

    if (cmd.exec) begin
      commit_pc = 1'b1;
      if (!word_r[WW-1]) begin
        unique case (op_r) inside
          OP_READ: begin
            ru_nxt = 1'b1;
            if (data_ok) begin
              we    = 1'b1;
              waddr = ad_r;
            end else begin
              st_nxt    = ST_BAD_READ;
              stop_nxt  = 1'b1;
              commit_pc = 1'b0;
            end
          end
          OP_WRITE: begin
            wv_nxt   = 1'b1;
            wval_nxt = rword;
          end
          OP_LOAD: acc_nxt = rword;
          OP_STORE: begin
            we    = 1'b1;
            waddr = ad_r;
            wdata = acc_r;
          end
          OP_ADD, OP_SUB: begin
            if ((t_as >= LIM_LO) && (t_as <= LIM_HI)) begin
              acc_nxt = t_as[WW-1:0];
            end else begin
              st_nxt    = ST_ACC_RNG;
              stop_nxt  = 1'b1;
              commit_pc = 1'b0;
            end
          end
          OP_DIV: begin
            commit_pc = 1'b0;
            if (rword == '0) begin
              st_nxt   = ST_DIV_ZERO;
              stop_nxt = 1'b1;
            end
          end
          OP_MUL: commit_pc = 1'b0;
          OP_BR: npc = ad_r;
          OP_BRNEG: begin
            if (acc_r[WW-1]) begin
              npc = ad_r;
            end
          end
          OP_BRZERO: begin
            if (acc_r == '0) begin
              npc = ad_r;
            end
          end
          OP_HALT: begin
            st_nxt    = ST_HALT;
            stop_nxt  = 1'b1;
            commit_pc = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.mdfin) begin
      if (md_mag > PROD_W'(WORD_MAX)) begin
        st_nxt   = ST_ACC_RNG;
        stop_nxt = 1'b1;
      end else begin
        acc_nxt   = md_neg ? md_negv : md_pos;
        commit_pc = 1'b1;
      end
    end

    if (commit_pc) begin
      pc_nxt = npc;
      if (npc >= AW'(MEM_WORDS)) begin
        st_nxt   = ST_OFF_END;
        stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pc_r   <= '0;
      stop_r <= 1'b0;
      vld_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      pc_r   <= pc_nxt;
      stop_r <= stop_nxt;
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
      rvld_r  <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r    <= item_req;
      ldaddr_r <= item_addr;
      data_r   <= item_data;
    end
    if (cmd.dec) begin
      word_r <= rword;
      op_r   <= dq;
      ad_r   <= da_full[AW-1:0];
    end
    st_r   <= st_nxt;
    wv_r   <= wv_nxt;
    wval_r <= wval_nxt;
    ru_r   <= ru_nxt;
    xw_r   <= xw_nxt;
    if (cmd.load_out) begin
      out_data_r <= {4'b0, xw_r, pc_r, acc_r, wval_r};
      out_user_r <= {ru_r, wv_r, st_r};
    end
  end

  assign out_data = out_data_r;
  assign out_user = out_user_r;

endmodule

`default_nettype wire

>>> rtl/dam_ctrl.sv
// ----------------------------------------------------------------------------
// dam_ctrl
// Sequencer for one item at a time, plus output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_accumulator_machine_defines.svh"

module dam_ctrl import dam_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output dam_cmd_t  cmd,
  input  dam_sts_t  sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_OPRD = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [2:0] S_MDW  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.disp  = 1'b1;
        state_nxt = sts.fetch_go ? S_DEC : S_DONE;
      end
      S_DEC: begin
        cmd.dec   = 1'b1;
        state_nxt = S_OPRD;
      end
      S_OPRD: begin
        cmd.oprd  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.md_go ? S_MDW : S_DONE;
      end
      S_MDW: begin
        if (sts.md_done) begin
          cmd.mdfin = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `DAM_CHK_NEXT(a_accept_disp, in_tvalid && in_tready, state_r == S_DISP, "item not dispatched")
  `DAM_CHK_NOW(a_load_free, cmd.load_out, !out_valid_r || out_tready, "result overwritten")
  `DAM_CHK_NOW(a_md_done_wait, sts.md_done, state_r == S_MDW, "stray mul/div done")
  `DAM_CHK_NEXT(a_md_enter, (state_r == S_EXEC) && sts.md_go, state_r == S_MDW, "mul/div skipped")

endmodule

`default_nettype wire

>>> rtl/decimal_accumulator_machine.sv
// ----------------------------------------------------------------------------
// decimal_accumulator_machine
// 100-word decimal accumulator machine: load, step and restart requests.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                              | tuser
//  in_     | in  | load_address[6:0], data_value[22:7], pad[23]    | req_type[1:0]
//  out_    | out | write_value[14:0], acc_value[29:15],            | status[2:0],
//          |     | next_pc[36:30], executed_word[51:37], pad       | write_valid[3],
//          |     |                                                 | read_used[4]
//
//  Load, restart, and execute on a stopped machine: capture, dispatch, done.
//  Execute: capture, dispatch/fetch, decode, operand read, execute, done;
//  multiply, and divide by a nonzero word, also wait on the shared bit-serial unit.
//  One item is in work at a time; the next is taken once its result sits in
//  the output register, which holds until out_tready.
//  Reset is synchronous; the word store reads as zero until written (per-word
//  valid bits), so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_accumulator_machine import dam_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // load_address, data_value
  input  logic [IN_TUSER_W-1:0]   in_tuser,   // req_type
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // write_value, acc_value, next_pc, executed_word
  output logic [OUT_TUSER_W-1:0]  out_tuser   // status, write_valid, read_used
);

  dam_cmd_t cmd;
  dam_sts_t sts;

  dam_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  dam_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .item_req  (in_tuser),
    .item_addr (in_tdata[AW-1:0]),
    .item_data ($signed(in_tdata[AW+DW-1:AW])),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

`default_nettype wire
